[hdl/htfd_pkg.sv]
`default_nettype none
package htfd_pkg;

	localparam logic [7:0] CRC_POLY = 8'h31;
	localparam logic [7:0] CRC_INIT = 8'hFF;

	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_BUS_ERR = 2'd1;
	localparam logic [1:0] STATUS_CRC_ERR = 2'd2;

	localparam int PROD_W = 31;

	localparam logic [14:0] TEMP_SCALE  = 15'd17500;
	localparam logic [14:0] HUM_SCALE   = 15'd12500;
	localparam logic [14:0] TEMP_OFFSET = 15'd4500;
	localparam logic [13:0] HUM_OFFSET  = 14'd600;
	localparam logic [13:0] HUM_MAX     = 14'd10000;

	typedef struct packed {
		logic [1:0]        status;
		logic [15:0]       temp_raw;
		logic [15:0]       hum_raw;
		logic [PROD_W-1:0] temp_prod;
		logic [PROD_W-1:0] hum_prod;
	} frame_res_t;

	function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

	// Floor of p / 65535 for p below 2**31: one estimate and one correction.
	function automatic logic [14:0] div_65535(input logic [PROD_W-1:0] p);
		logic [14:0] q0;
		logic [16:0] rem;
		q0 = p[PROD_W-1:16];
		rem = {1'b0, p[15:0]} + {2'b00, q0};
		return q0 + ((rem >= 17'd65535) ? 15'd1 : 15'd0);
	endfunction

endpackage
`default_nettype wire

[hdl/htfd_frame.sv]
`default_nettype none
module htfd_frame (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               step,
	input  wire logic               adv,
	input  wire logic [7:0]         rx_byte,
	input  wire logic               bus_error,
	output logic                    res_valid_s2,
	output htfd_pkg::frame_res_t    res_s2
);
	import htfd_pkg::*;

	localparam logic [2:0] POS_T_MSB = 3'd0;
	localparam logic [2:0] POS_T_LSB = 3'd1;
	localparam logic [2:0] POS_T_CRC = 3'd2;
	localparam logic [2:0] POS_H_MSB = 3'd3;
	localparam logic [2:0] POS_H_LSB = 3'd4;
	localparam logic [2:0] POS_H_CRC = 3'd5;

	logic [2:0]  pos_q, pos_d, pos_eff;
	logic [7:0]  crc_q, crc_d, crc_next;
	logic [15:0] tword_q, tword_d;
	logic [15:0] hword_q, hword_d;
	logic        fail_q, fail_d;
	logic [15:0] good_t_q, good_t_d;
	logic [15:0] good_h_q, good_h_d;
	logic        emit;
	logic [1:0]  status;

	assign crc_next = crc_byte(crc_q, rx_byte);

	always_comb begin
		pos_eff  = (pos_q > POS_H_CRC) ? POS_T_MSB : pos_q;
		pos_d    = pos_eff + 3'd1;
		crc_d    = crc_q;
		tword_d  = tword_q;
		hword_d  = hword_q;
		fail_d   = fail_q;
		good_t_d = good_t_q;
		good_h_d = good_h_q;
		emit     = 1'b0;
		status   = STATUS_OK;
		if (bus_error) begin
			pos_d   = POS_T_MSB;
			crc_d   = CRC_INIT;
			fail_d  = 1'b0;
			tword_d = '0;
			hword_d = '0;
			emit    = 1'b1;
			status  = STATUS_BUS_ERR;
		end else begin
			case (pos_eff)
				POS_T_MSB: begin
					tword_d = {rx_byte, 8'h00};
					crc_d   = crc_next;
				end
				POS_T_LSB: begin
					tword_d = {tword_q[15:8], rx_byte};
					crc_d   = crc_next;
				end
				POS_T_CRC: begin
					if (crc_q != rx_byte) begin
						fail_d = 1'b1;
					end
					crc_d = CRC_INIT;
				end
				POS_H_MSB: begin
					hword_d = {rx_byte, 8'h00};
					crc_d   = crc_next;
				end
				POS_H_LSB: begin
					hword_d = {hword_q[15:8], rx_byte};
					crc_d   = crc_next;
				end
				default: begin
					emit = 1'b1;
					if (fail_q || (crc_q != rx_byte)) begin
						status = STATUS_CRC_ERR;
					end else begin
						status   = STATUS_OK;
						good_t_d = tword_q;
						good_h_d = hword_q;
					end
					pos_d  = POS_T_MSB;
					crc_d  = CRC_INIT;
					fail_d = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= POS_T_MSB;
			crc_q    <= CRC_INIT;
			tword_q  <= '0;
			hword_q  <= '0;
			fail_q   <= 1'b0;
			good_t_q <= '0;
			good_h_q <= '0;
		end else if (step) begin
			pos_q    <= pos_d;
			crc_q    <= crc_d;
			tword_q  <= tword_d;
			hword_q  <= hword_d;
			fail_q   <= fail_d;
			good_t_q <= good_t_d;
			good_h_q <= good_h_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (adv) begin
			res_valid_s2 <= step && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			res_s2.status    <= status;
			res_s2.temp_raw  <= good_t_d;
			res_s2.hum_raw   <= good_h_d;
			res_s2.temp_prod <= {15'd0, good_t_d} * {16'd0, TEMP_SCALE};
			res_s2.hum_prod  <= {15'd0, good_h_d} * {16'd0, HUM_SCALE};
		end
	end

endmodule
`default_nettype wire

[hdl/htfd_convert.sv]
`default_nettype none
module htfd_convert (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 res_valid_s2,
	input  wire htfd_pkg::frame_res_t res_s2,
	input  wire logic                 out_ready,
	output logic                      adv,
	output logic                      out_valid,
	output logic [1:0]                status,
	output logic [15:0]               temperature_raw,
	output logic [15:0]               humidity_raw,
	output logic signed [14:0]        temperature_centi,
	output logic [13:0]               humidity_centi
);
	import htfd_pkg::*;

	logic [14:0] tq;
	logic [14:0] hq;
	logic [13:0] hum_c;

	assign adv = !out_valid || out_ready;
	assign tq  = div_65535(res_s2.temp_prod);
	assign hq  = div_65535(res_s2.hum_prod);

	always_comb begin
		if (hq < {1'b0, HUM_OFFSET}) begin
			hum_c = '0;
		end else if (hq - {1'b0, HUM_OFFSET} > {1'b0, HUM_MAX}) begin
			hum_c = HUM_MAX;
		end else begin
			hum_c = 14'(hq - {1'b0, HUM_OFFSET});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= res_valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_valid_s2) begin
			status            <= res_s2.status;
			temperature_raw   <= res_s2.temp_raw;
			humidity_raw      <= res_s2.hum_raw;
			temperature_centi <= signed'(tq - TEMP_OFFSET);
			humidity_centi    <= hum_c;
		end
	end

endmodule
`default_nettype wire

[hdl/humidity_temp_frame_decoder.sv]
// Path: an input byte is registered in s1, its frame result in res_s2, then the output register.
// Throughput: one byte per cycle unless out_ready stalls the output; CRC logic is combinational.
// One result follows each sixth frame byte and each bus-error byte, others give none.
// Reset clears the frame position, words and last good values and sets the CRC to
// its initial value; results before a good frame report -4500 and 0 as converted values.
`default_nettype none
module humidity_temp_frame_decoder (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [7:0]         rx_byte,
	input  wire logic               bus_error,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [1:0]              status,
	output logic [15:0]             temperature_raw,
	output logic [15:0]             humidity_raw,
	output logic signed [14:0]      temperature_centi,
	output logic [13:0]             humidity_centi
);
	import htfd_pkg::*;

	logic        valid_s1;
	logic [7:0]  rx_byte_s1;
	logic        bus_error_s1;
	logic        adv_out;
	logic        adv_s2;
	logic        step;
	logic        res_valid_s2;
	frame_res_t  res_s2;

	assign adv_s2   = !res_valid_s2 || adv_out;
	assign step     = valid_s1 && adv_s2;
	assign in_ready = !valid_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			rx_byte_s1   <= rx_byte;
			bus_error_s1 <= bus_error;
		end
	end

	htfd_frame u_frame (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.adv          (adv_s2),
		.rx_byte      (rx_byte_s1),
		.bus_error    (bus_error_s1),
		.res_valid_s2 (res_valid_s2),
		.res_s2       (res_s2)
	);

	htfd_convert u_convert (
		.clk               (clk),
		.arst_n            (arst_n),
		.res_valid_s2      (res_valid_s2),
		.res_s2            (res_s2),
		.out_ready         (out_ready),
		.adv               (adv_out),
		.out_valid         (out_valid),
		.status            (status),
		.temperature_raw   (temperature_raw),
		.humidity_raw      (humidity_raw),
		.temperature_centi (temperature_centi),
		.humidity_centi    (humidity_centi)
	);

endmodule
`default_nettype wire
